>>> rtl/ghsm_pkg.sv
// types and codes shared by the generational handle slot map
`timescale 1ns / 1ps
`default_nettype none

package ghsm_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned HIDX_W   = 12;
  localparam int unsigned GEN_W    = 32;
  localparam int unsigned OBJ_PORT_W = 32;
  localparam int unsigned STATUS_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [HIDX_W-1:0]     handle_index;
    logic [GEN_W-1:0]      handle_generation;
    logic [OBJ_PORT_W-1:0] object_ref;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [HIDX_W-1:0]     out_index;
    logic [GEN_W-1:0]      out_generation;
    logic [OBJ_PORT_W-1:0] out_object;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/generational_handle_slot_map_top.sv
// generational handle slot map: slot table, free list and request sequencer
// result path: slot record registered at accept, result registered at execute (slot read, then write back)
// one item at a time: a new item is accepted only after the last one leaves execute,
//   set by the single slot memory port pair and the free head / fill count update that the next item depends on
// a waiting result holds the next item in execute; reset clears the sequencer,
//   free head (empty) and fill count, not the slot memory (live only below fill count)
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_slot_map_top
  import ghsm_pkg::*;
#(
  parameter int SLOTS     = 4096,
  parameter int REF_WIDTH = 32
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // free head and fill count must also hold the value SLOTS (empty / all taken)
  localparam int PTR_W = $clog2(SLOTS + 1);
  // compare width for handle index against fill count
  localparam int CMP_W = (PTR_W > HIDX_W) ? PTR_W : HIDX_W;
  // object bits actually kept in the table
  localparam int OBJ_W = (REF_WIDTH < OBJ_PORT_W) ? REF_WIDTH : OBJ_PORT_W;

  localparam logic [PTR_W-1:0] FREE_NONE = PTR_W'(SLOTS);

  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
    logic [PTR_W-1:0] next;
    logic [OBJ_W-1:0] obj;
  } slot_rec_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [PTR_W-1:0] free_head_q, free_head_d;
  logic [PTR_W-1:0] slots_used_q, slots_used_d;

  req_t             req_q;
  logic [IDX_W-1:0] addr_q;
  slot_rec_t        rd_q;

  rsp_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  // slot table, one record per slot
  slot_rec_t slot_mem_q [SLOTS];

  logic             in_accept;
  logic             exec_go;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  slot_rec_t        mem_wdata;

  logic             free_nonempty;
  logic             fresh_left;
  logic             handle_live;
  logic             gen_match;
  logic [GEN_W-1:0] gen_inc;
  logic [GEN_W-1:0] gen_bump;
  rsp_t             rsp;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // result may move into the output register once it is empty or being taken
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign free_nonempty = (free_head_q != FREE_NONE);
  assign fresh_left    = (slots_used_q != PTR_W'(SLOTS));

  // read address: register takes free head, else the next untouched slot
  always_comb begin
    if (in_req_i.req_type == REQ_REGISTER) begin
      mem_raddr = free_nonempty ? free_head_q[IDX_W-1:0] : slots_used_q[IDX_W-1:0];
    end else begin
      mem_raddr = IDX_W'(in_req_i.handle_index);
    end
  end

  // live only counts below the fill count; slots at or above it were never written
  assign handle_live = rd_q.live && (CMP_W'(req_q.handle_index) < CMP_W'(slots_used_q));
  assign gen_match   = (rd_q.gen == req_q.handle_generation);
  assign gen_inc     = rd_q.gen + GEN_W'(1);
  // generation wraps past zero to one
  assign gen_bump    = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

  // request execution on the record registered at accept
  always_comb begin
    rsp          = '0;
    mem_we       = 1'b0;
    mem_wdata    = rd_q;
    free_head_d  = free_head_q;
    slots_used_d = slots_used_q;
    case (req_q.req_type)
      REQ_REGISTER: begin
        if (free_nonempty || fresh_left) begin
          rsp.status         = ST_OK;
          rsp.out_index      = HIDX_W'(addr_q);
          rsp.out_generation = free_nonempty ? rd_q.gen : GEN_W'(1);
          mem_we             = 1'b1;
          mem_wdata.live     = 1'b1;
          mem_wdata.gen      = rsp.out_generation;
          mem_wdata.next     = FREE_NONE;
          mem_wdata.obj      = OBJ_W'(req_q.object_ref);
          if (free_nonempty) begin
            free_head_d = rd_q.next;
          end else begin
            slots_used_d = slots_used_q + PTR_W'(1);
          end
        end else begin
          rsp.status = ST_FULL;
        end
      end
      REQ_RELEASE: begin
        if (handle_live && gen_match) begin
          rsp.status     = ST_OK;
          mem_we         = 1'b1;
          mem_wdata.live = 1'b0;
          mem_wdata.gen  = gen_bump;
          mem_wdata.next = free_head_q;
          mem_wdata.obj  = '0;
          free_head_d    = PTR_W'(addr_q);
        end else begin
          rsp.status = ST_STALE;
        end
      end
      REQ_LOOKUP: begin
        if (handle_live && gen_match) begin
          rsp.status     = ST_OK;
          rsp.out_object = OBJ_PORT_W'(rd_q.obj);
        end else begin
          rsp.status = ST_STALE;
        end
      end
      default: begin
        // unknown request type
        rsp.status = ST_STALE;
      end
    endcase
  end

  // sequencer and output register
  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          out_d       = rsp;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      free_head_q  <= FREE_NONE;
      slots_used_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_go) begin
        free_head_q  <= free_head_d;
        slots_used_q <= slots_used_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_accept) begin
      req_q  <= in_req_i;
      addr_q <= mem_raddr;
    end
  end

  // slot memory: registered read at accept, write back at execute
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= slot_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go && mem_we) begin
      slot_mem_q[addr_q] <= mem_wdata;
    end
  end

`ifndef SYNTH
  // an accepted item is in the execute state in the following cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_EXEC))
    else $error("accepted item did not reach execute");

  // a new result only comes out of the execute state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result appeared without execute");

  // fill count and free head never leave their range
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CMP_W'(slots_used_q) <= CMP_W'(SLOTS)) && (CMP_W'(free_head_q) <= CMP_W'(SLOTS)))
    else $error("free head or fill count out of range");

  // the free list head is always a slot that was already taken
  a_head_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q != FREE_NONE) |-> (free_head_q < slots_used_q))
    else $error("free head points at an untaken slot");
`endif

endmodule

`default_nettype wire

>>> test/ghsm_checker.sv
// scoreboard for the slot map: predicts every result and compares it field by field
`timescale 1ns / 1ps
`default_nettype none

module ghsm_checker
  import ghsm_pkg::*;
#(
  parameter int SLOTS = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_stall_i,
  input  req_t        in_req_i,
  input  wire         out_valid_i,
  input  wire         out_stall_i,
  input  rsp_t        out_rsp_i,
  output int unsigned err_count_o,
  output int unsigned pending_o
);

  localparam int LINK_W = $clog2(SLOTS) + 1;
  localparam logic [LINK_W-1:0] FREE_EMPTY = LINK_W'(SLOTS);

  // shadow of the slot table
  logic [OBJ_PORT_W-1:0] slot_obj  [SLOTS];
  logic [GEN_W-1:0]      slot_gen  [SLOTS];
  logic [LINK_W-1:0]     slot_link [SLOTS];
  bit                    slot_live [SLOTS];
  logic [LINK_W-1:0]     free_head;
  int unsigned           fill_count;

  rsp_t pending_results[$];

  // applies one request to the shadow table and returns its result
  function automatic rsp_t resolve_request(input req_t r);
    rsp_t             res;
    int unsigned      slot;
    bit               handle_ok;
    bit               granted;
    logic [GEN_W-1:0] bumped;
    res       = '0;
    granted   = 1'b1;
    handle_ok = (r.handle_index < SLOTS) && slot_live[r.handle_index] &&
                (slot_gen[r.handle_index] == r.handle_generation);
    case (r.req_type)
      REQ_REGISTER: begin
        if (free_head != FREE_EMPTY) begin
          slot      = 32'(free_head);
          free_head = slot_link[slot];
        end else if (fill_count < SLOTS) begin
          slot           = fill_count;
          fill_count     = fill_count + 1;
          slot_gen[slot] = 1;
        end else begin
          granted    = 1'b0;
          res.status = ST_FULL;
        end
        if (granted) begin
          slot_obj[slot]     = r.object_ref;
          slot_link[slot]    = FREE_EMPTY;
          slot_live[slot]    = 1'b1;
          res.status         = ST_OK;
          res.out_index      = HIDX_W'(slot);
          res.out_generation = slot_gen[slot];
        end
      end
      REQ_RELEASE: begin
        if (!handle_ok) begin
          res.status = ST_STALE;
        end else begin
          slot_obj[r.handle_index]  = '0;
          slot_live[r.handle_index] = 1'b0;
          bumped = slot_gen[r.handle_index] + 1'b1;
          // generation zero is never handed out
          slot_gen[r.handle_index]  = (bumped == '0) ? GEN_W'(1) : bumped;
          slot_link[r.handle_index] = free_head;
          free_head  = LINK_W'(r.handle_index);
          res.status = ST_OK;
        end
      end
      REQ_LOOKUP: begin
        if (!handle_ok) begin
          res.status = ST_STALE;
        end else begin
          res.status     = ST_OK;
          res.out_object = slot_obj[r.handle_index];
        end
      end
      default: res.status = ST_STALE;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [GEN_W-1:0] want_v,
                             input logic [GEN_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      err_count_o = err_count_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      free_head   = FREE_EMPTY;
      fill_count  = 0;
      err_count_o = 0;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      // results first: a result never belongs to the item accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_rsp_i);
          err_count_o = err_count_o + 1;
        end else begin
          want = pending_results.pop_front();
          check_field("status", GEN_W'(want.status), GEN_W'(out_rsp_i.status));
          check_field("out_index", GEN_W'(want.out_index), GEN_W'(out_rsp_i.out_index));
          check_field("out_generation", want.out_generation, out_rsp_i.out_generation);
          check_field("out_object", want.out_object, out_rsp_i.out_object);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_results.insert(pending_results.size(), resolve_request(in_req_i));
      end
      pending_o <= pending_results.size();
    end
  end

endmodule

`default_nettype wire

>>> test/tb_generational_handle_slot_map_top.sv
// testbench top for the generational handle slot map: stimulus, handshakes and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_generational_handle_slot_map_top;
  import ghsm_pkg::*;

  localparam int SLOTS     = 4096;
  localparam int REF_WIDTH = 32;

  // request type with no meaning, answered as a stale handle
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // a handle as the block hands it out
  typedef struct packed {
    logic [HIDX_W-1:0] idx;
    logic [GEN_W-1:0]  gen;
  } slot_handle_t;

  logic clk_i;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_req    = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  int unsigned mismatches;
  int unsigned outstanding;

  // idle rates in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // handles the block has issued and not yet been asked to release,
  // and a short history of released ones for stale traffic
  slot_handle_t live_handles[$];
  slot_handle_t dead_handles[$];

  generational_handle_slot_map_top #(
    .SLOTS    (SLOTS),
    .REF_WIDTH(REF_WIDTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp_o)
  );

  ghsm_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall),
    .out_rsp_i  (out_rsp_o),
    .err_count_o(mismatches),
    .pending_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side: random stall at the configured rate
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // learn issued handles from accepted register results; only a register
  // result carries a nonzero generation
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall && out_rsp_o.status == ST_OK &&
        out_rsp_o.out_generation != '0) begin
      live_handles.insert(live_handles.size(),
        slot_handle_t'{idx: out_rsp_o.out_index, gen: out_rsp_o.out_generation});
    end
  end

  function automatic req_t make_req(input logic [REQ_W-1:0] kind,
                                    input logic [HIDX_W-1:0] idx,
                                    input logic [GEN_W-1:0] gen,
                                    input logic [OBJ_PORT_W-1:0] obj);
    req_t r;
    r.req_type          = kind;
    r.handle_index      = idx;
    r.handle_generation = gen;
    r.object_ref        = obj;
    return r;
  endfunction

  // random request: mostly well-formed traffic on issued handles, some stale
  // handles and a few unknown types; unused fields always carry random bits
  function automatic req_t next_request(input int unsigned register_pct);
    req_t         r;
    slot_handle_t h;
    int unsigned  roll;
    int unsigned  pick;
    r    = make_req(REQ_REGISTER, HIDX_W'($urandom), $urandom, $urandom);
    roll = $urandom_range(99);
    if (roll < register_pct) begin
      r.req_type = REQ_REGISTER;
    end else if (roll < 92) begin
      // valid handle, released or looked up
      if (live_handles.size() != 0) begin
        pick = $urandom_range(live_handles.size() - 1);
        h    = live_handles[pick];
        r.handle_index      = h.idx;
        r.handle_generation = h.gen;
        if ($urandom_range(1)) begin
          r.req_type = REQ_RELEASE;
          live_handles.delete(pick);
          dead_handles.insert(dead_handles.size(), h);
          if (dead_handles.size() > 64) void'(dead_handles.pop_front());
        end else begin
          r.req_type = REQ_LOOKUP;
        end
      end
    end else if (roll < 98) begin
      // stale: old generation, wrong generation or a random handle
      r.req_type = $urandom_range(1) ? REQ_RELEASE : REQ_LOOKUP;
      case ($urandom_range(2))
        0: if (dead_handles.size() != 0) begin
          h = dead_handles[$urandom_range(dead_handles.size() - 1)];
          r.handle_index      = h.idx;
          r.handle_generation = h.gen;
        end
        1: if (live_handles.size() != 0) begin
          h = live_handles[$urandom_range(live_handles.size() - 1)];
          r.handle_index      = h.idx;
          r.handle_generation = h.gen ^ GEN_W'($urandom_range(32'hFFFF_FFFE) + 1);
        end
        default: ;
      endcase
    end else begin
      r.req_type = REQ_UNKNOWN;
    end
    return r;
  endfunction

  // offer one item, with a random gap first, and hold it until accepted
  task automatic send_item(input req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // phase one: sender idles now and then, receiver often
    send_idle_pct = 26;
    recv_idle_pct = 46;

    // directed: handles on slots never taken, unknown type with all ones
    send_item(make_req(REQ_LOOKUP, 12'd0, 32'd1, 32'd0));
    send_item(make_req(REQ_RELEASE, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_req(REQ_UNKNOWN, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // fresh slots 0 and 1 at generation 1, object extremes
    send_item(make_req(REQ_REGISTER, 12'd0, 32'd0, 32'd0));
    send_item(make_req(REQ_REGISTER, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_req(REQ_LOOKUP, 12'd0, 32'd1, 32'd0));
    send_item(make_req(REQ_LOOKUP, 12'd1, 32'd1, 32'hFFFF_FFFF));
    // generation mismatch on a live slot
    send_item(make_req(REQ_LOOKUP, 12'd1, 32'd2, 32'd0));
    send_item(make_req(REQ_LOOKUP, 12'd1, 32'hFFFF_FFFF, 32'd0));
    // release, then double release and a release of a free slot whose
    // generation already matches
    send_item(make_req(REQ_RELEASE, 12'd0, 32'd1, 32'd0));
    send_item(make_req(REQ_RELEASE, 12'd0, 32'd1, 32'd0));
    send_item(make_req(REQ_RELEASE, 12'd0, 32'd2, 32'd0));
    send_item(make_req(REQ_LOOKUP, 12'd0, 32'd2, 32'd0));
    // reuse from the free list keeps the bumped generation
    send_item(make_req(REQ_REGISTER, 12'd0, 32'd0, 32'hA5A5_A5A5));
    send_item(make_req(REQ_LOOKUP, 12'd0, 32'd2, 32'd0));
    // two on the free list, taken back last in first out, then a new slot
    send_item(make_req(REQ_RELEASE, 12'd1, 32'd1, 32'd0));
    send_item(make_req(REQ_RELEASE, 12'd0, 32'd2, 32'd0));
    send_item(make_req(REQ_REGISTER, 12'd0, 32'd0, 32'h5A5A_5A5A));
    send_item(make_req(REQ_REGISTER, 12'd0, 32'd0, 32'd1));
    send_item(make_req(REQ_REGISTER, 12'd0, 32'd0, 32'h8000_0000));
    send_item(make_req(REQ_LOOKUP, 12'd2, 32'd1, 32'd0));
    send_item(make_req(REQ_LOOKUP, 12'hFFF, 32'd0, 32'd0));
    send_item(make_req(REQ_UNKNOWN, 12'd0, 32'd0, 32'd0));

    repeat (580) send_item(next_request(40));

    // phase two: rates swapped
    send_idle_pct = 46;
    recv_idle_pct = 26;
    repeat (600) send_item(next_request(30));

    // phase three: back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (600) send_item(next_request(40));

    in_valid <= 1'b0;
    // the checker's pending count is registered and so lags the last accepted item
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
